/* rtl/bde_pkg.sv */
// shared types and constants of the byte deque engine
// depends on nothing; used by bde_cell and byte_deque_engine_core
package bde_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;

  // request kinds carried in s_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_t;

  // result status carried in m_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_DATA  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [BYTE_W-1:0]   wdata;
  } cell_ctl_t;

endpackage

/* rtl/byte_deque_engine_core.sv */
// top level of the byte deque engine: control, chain of cells, output register
// depends on bde_pkg and bde_cell
//
// usage
//   a bounded double-ended queue of bytes held in a row of DEPTH cells; the
//   front entry always sits in cell 0 and the back in cell occupancy-1
//   input channel s_*: s_tuser is the request kind (push front, push back,
//   pop front, pop back, dump), s_tdata the byte to push
//   output channel m_*: m_tuser is the status (data, empty, full), m_tdata
//   the byte (zero unless status is data), m_tlast marks the final result
//   of a request
//   a push gives no result unless the queue is full; a pop or a refused push
//   gives its result in the output register in the cycle after the transaction
//   a dump walks the chain, one result per cycle while the receiver keeps up,
//   rotating the front byte round to the back, and leaves the queue as it was;
//   other requests can be taken back to back while the receiver keeps up
//   s_tready is high when no dump is under way and the output register is
//   free or being emptied in the same cycle
//   when the receiver stalls the output register holds its result and the
//   dump walk pauses; nothing is lost
//   reset (rst, synchronous) empties the queue and the output register;
//   cell contents are not cleared and are only read after being written
module byte_deque_engine_core #(
  parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bde_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] value
  input  logic [bde_pkg::KIND_W-1:0]      s_tuser,   // [2:0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bde_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] data_byte
  output logic [bde_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
  output logic                            m_tlast
);

  localparam int CW = $clog2(DEPTH + 1);   // occupancy, 0 to DEPTH
  localparam int IW = $clog2(DEPTH);       // dump walk position
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t             state;
  logic [CW-1:0]      occupancy;
  logic [IW-1:0]      walk;

  logic                          out_free;
  logic                          acc_in;
  logic                          full;
  logic                          empty;
  logic                          dump_step;
  logic [bde_pkg::BYTE_W-1:0]    back_byte;
  logic [bde_pkg::BYTE_W-1:0]    wdata;

  bde_pkg::cell_ctl_t            ctl  [DEPTH];
  logic [bde_pkg::BYTE_W-1:0]    cdat [DEPTH];
  logic                          back_sel [DEPTH];

  // the output register frees when empty or when taken this cycle
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign acc_in    = s_tvalid && s_tready;
  assign full      = (occupancy == FULL_C);
  assign empty     = (occupancy == '0);
  assign dump_step = (state == ST_DUMP) && out_free;

  // write byte: pushed value, or the front byte rotated round during a dump
  assign wdata = (state == ST_DUMP) ? cdat[0] : s_tdata;

  // back entry pick: one-hot over cells, and-or of independent lanes
  always_comb begin
    back_byte = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_byte = back_byte | (cdat[i] & {bde_pkg::BYTE_W{back_sel[i]}});
    end
  end

  // per-cell control and the chain itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(i);
    localparam logic [CW-1:0] IDX1 = CW'(i + 1);

    logic [bde_pkg::BYTE_W-1:0] left_in;
    logic [bde_pkg::BYTE_W-1:0] right_in;

    assign back_sel[i] = (occupancy == IDX1);

    if (i == 0) begin : g_first
      assign left_in = wdata;
    end else begin : g_mid_l
      assign left_in = cdat[i-1];
    end

    // the far end of the chain only feeds itself back
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cdat[i];
    end else begin : g_mid_r
      assign right_in = cdat[i+1];
    end

    always_comb begin
      ctl[i].wdata = wdata;
      ctl[i].op    = bde_pkg::CELL_HOLD;
      if (dump_step) begin
        // rotate left: the back slot takes the old front byte
        ctl[i].op = back_sel[i] ? bde_pkg::CELL_LOAD : bde_pkg::CELL_FROM_RIGHT;
      end else if (acc_in) begin
        case (s_tuser)
          bde_pkg::KIND_PUSH_FRONT: begin
            if (!full) ctl[i].op = bde_pkg::CELL_FROM_LEFT;
          end
          bde_pkg::KIND_PUSH_BACK: begin
            if (!full && occupancy == IDX) ctl[i].op = bde_pkg::CELL_LOAD;
          end
          bde_pkg::KIND_POP_FRONT: begin
            if (!empty) ctl[i].op = bde_pkg::CELL_FROM_RIGHT;
          end
          default: ctl[i].op = bde_pkg::CELL_HOLD;
        endcase
      end
    end

    bde_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cdat[i])
    );
  end

  // control state, occupancy and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      walk      <= '0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tuser   <= bde_pkg::STAT_DATA;
      m_tlast   <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc_in) begin
            case (s_tuser)
              bde_pkg::KIND_PUSH_FRONT, bde_pkg::KIND_PUSH_BACK: begin
                if (full) begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= bde_pkg::STAT_FULL;
                  m_tdata  <= '0;
                  m_tlast  <= 1'b1;
                end else begin
                  occupancy <= occupancy + ONE_C;
                end
              end
              bde_pkg::KIND_POP_FRONT, bde_pkg::KIND_POP_BACK: begin
                m_tvalid <= 1'b1;
                m_tlast  <= 1'b1;
                if (empty) begin
                  m_tuser <= bde_pkg::STAT_EMPTY;
                  m_tdata <= '0;
                end else begin
                  m_tuser   <= bde_pkg::STAT_DATA;
                  m_tdata   <= (s_tuser == bde_pkg::KIND_POP_FRONT) ? cdat[0]
                                                                    : back_byte;
                  occupancy <= occupancy - ONE_C;
                end
              end
              bde_pkg::KIND_DUMP: begin
                if (empty) begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= bde_pkg::STAT_EMPTY;
                  m_tdata  <= '0;
                  m_tlast  <= 1'b1;
                end else begin
                  state <= ST_DUMP;
                  walk  <= '0;
                end
              end
              default: begin
                // unused kinds are taken and dropped
              end
            endcase
          end
        end
        ST_DUMP: begin
          if (dump_step) begin
            m_tvalid <= 1'b1;
            m_tuser  <= bde_pkg::STAT_DATA;
            m_tdata  <= cdat[0];
            if (CW'(walk) + ONE_C == occupancy) begin
              m_tlast <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              m_tlast <= 1'b0;
              walk    <= walk + IW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // occupancy never runs past DEPTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FULL_C)
    else $error("occupancy beyond depth");

  // non-data results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != bde_pkg::STAT_DATA) |-> (m_tdata == '0))
    else $error("status result with non-zero byte");

  // an accepted push into a non-full queue grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (acc_in && !full && (s_tuser == bde_pkg::KIND_PUSH_FRONT ||
                         s_tuser == bde_pkg::KIND_PUSH_BACK))
    |=> (occupancy == $past(occupancy) + ONE_C))
    else $error("push did not grow occupancy");

  // a dump leaves the occupancy untouched
  a_dump_keep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> (occupancy == $past(occupancy)))
    else $error("occupancy changed during dump");
`endif

endmodule

/* rtl/bde_cell.sv */
// one storage cell of the deque chain: holds a byte, takes a neighbour's
// byte or a write byte; depends on bde_pkg
module bde_cell (
  input  logic                          clk,
  input  bde_pkg::cell_ctl_t            ctl,
  input  logic [bde_pkg::BYTE_W-1:0]    left_data,
  input  logic [bde_pkg::BYTE_W-1:0]    right_data,
  output logic [bde_pkg::BYTE_W-1:0]    data
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      bde_pkg::CELL_FROM_LEFT:  data <= left_data;
      bde_pkg::CELL_FROM_RIGHT: data <= right_data;
      bde_pkg::CELL_LOAD:       data <= ctl.wdata;
      default:                  data <= data;
    endcase
  end

endmodule
